// ----- sv/assert_macros.svh -----
// Assertion macros for checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("check failed");
`endif

// ----- sv/nllp_pkg.sv -----
// Types, constants and tanh table for the ladder low-pass core.
// No dependencies.
package nllp_pkg;
  localparam int CHANNELS_D = 2;
  localparam int STAGES_D = 4;
  localparam int SAMPLE_WIDTH_D = 24;
  localparam int DW = 40;
  localparam logic signed [39:0] HALF_PI = 40'sd1647099;
  localparam logic signed [39:0] STAGE_LIM = 40'sd4194304;
  localparam logic signed [39:0] ONE_Q20 = 40'sd1048576;
  localparam logic [1:0] REG_DRIVE = 2'd0;
  localparam logic [1:0] REG_CUTOFF = 2'd1;
  localparam logic [1:0] REG_RES = 2'd2;
  localparam logic [1:0] REG_CLIP = 2'd3;

  typedef struct packed {
    logic [SAMPLE_WIDTH_D-1:0] sample;
    logic channel;
    logic block_end;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH_D-1:0] out_sample;
    logic block_end_out;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DRIVE, S_TD, S_FB, S_TIN, S_TST, S_UPD, S_SQ, S_CUBE, S_CLIP, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;

  function automatic logic [19:0] tanh_tab(input logic [4:0] k);
    case (k)
      5'd0: tanh_tab = 20'd0;       5'd1: tanh_tab = 20'd65451;
      5'd2: tanh_tab = 20'd130394;  5'd3: tanh_tab = 20'd194336;
      5'd4: tanh_tab = 20'd256816;  5'd5: tanh_tab = 20'd317413;
      5'd6: tanh_tab = 20'd375765;  5'd7: tanh_tab = 20'd431562;
      5'd8: tanh_tab = 20'd484565;  5'd9: tanh_tab = 20'd534596;
      5'd10: tanh_tab = 20'd581540; 5'd11: tanh_tab = 20'd625343;
      5'd12: tanh_tab = 20'd666002; 5'd13: tanh_tab = 20'd703560;
      5'd14: tanh_tab = 20'd738099; 5'd15: tanh_tab = 20'd769728;
      5'd16: tanh_tab = 20'd798589; 5'd17: tanh_tab = 20'd824830;
      5'd18: tanh_tab = 20'd848614; 5'd19: tanh_tab = 20'd870110;
      5'd20: tanh_tab = 20'd889490; 5'd21: tanh_tab = 20'd906921;
      5'd22: tanh_tab = 20'd922565; 5'd23: tanh_tab = 20'd936581;
      5'd24: tanh_tab = 20'd949116; 5'd25: tanh_tab = 20'd960312;
      5'd26: tanh_tab = 20'd970296;
      default: tanh_tab = 20'd0;
    endcase
  endfunction
endpackage

// ----- sv/nllp_serial_mul.sv -----
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on nllp_pkg.
module nllp_serial_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [nllp_pkg::DW-1:0] a,
  input  logic signed [nllp_pkg::DW-1:0] b,
  output logic signed [2*nllp_pkg::DW-1:0] p,
  output nllp_pkg::mul_ctl_t            ctl
);
  localparam int W = nllp_pkg::DW;
  logic [$clog2(W+1)-1:0] cnt_r, cnt_nxt;
  logic signed [2*W-1:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic [W-1:0] mb_r, mb_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mb_nxt = mb_r;
    if (start) begin
      cnt_nxt = ($clog2(W+1))'(W);
      acc_nxt = '0;
      mc_nxt = (2*W)'(a);
      mb_nxt = b;
    end else if (cnt_r != 0) begin
      if (mb_r[0]) begin
        if (cnt_r == 1) acc_nxt = acc_r - mc_r;
        else acc_nxt = acc_r + mc_r;
      end
      mc_nxt = mc_r <<< 1;
      mb_nxt = mb_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mb_r <= mb_nxt;
  end

  assign p = acc_r;
  assign ctl.start = start;
  assign ctl.busy = (cnt_r != 0);
endmodule

// ----- sv/nonlinear_ladder_lowpass_core.sv -----
// Top level of the four-pole nonlinear ladder low-pass core.
// Depends on nllp_pkg and nllp_serial_mul.
// The core takes a new item only in the idle state, that is after the previous result has
// reached the output register. A sequencer runs all 18 products through one bit-serial
// 40-bit multiplier, each as a start step, a settle step and one multiplier step per
// multiplier bit. The products are drive, tanh of the driven input, feedback, two tanh
// interpolations and one update per stage, and three for the cubic clip. The S_OUT state
// then moves the result to the output register. That shared multiplier sets the rate.
// A finished result waits in the output register while the next item is taken and
// processed. The sequencer holds in its last step only while that result still waits.
module nonlinear_ladder_lowpass_core #(
  parameter int CHANNELS = nllp_pkg::CHANNELS_D,
  parameter int STAGES = nllp_pkg::STAGES_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nllp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nllp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_wdata
);
  localparam int SAMPLE_WIDTH = nllp_pkg::SAMPLE_WIDTH_D;
  localparam int W = nllp_pkg::DW;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KW = $clog2(STAGES);
  typedef logic signed [W-1:0] d_t;

  logic [15:0] drive_r;
  logic [16:0] cut_r, clip_r;
  logic [14:0] res_r;
  logic signed [23:0] st_r [CHANNELS*STAGES];

  nllp_pkg::state_t state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [CW-1:0] ch_r, ch_nxt;
  d_t x_r, x_nxt, prev_r, prev_nxt, t_r, t_nxt, xc_r, xc_nxt, sq_r, sq_nxt;
  d_t tb_r, tb_nxt, ta_r, ta_nxt;
  logic tneg_r, tneg_nxt, be_r, be_nxt;
  logic ov_r, ov_nxt;
  logic [SAMPLE_WIDTH-1:0] os_r, os_nxt;
  logic obe_r, obe_nxt;
  logic st_we;
  logic signed [23:0] st_wd;

  logic m_start;
  d_t m_a, m_b;
  logic signed [2*W-1:0] m_p;
  nllp_pkg::mul_ctl_t m_ctl;

  nllp_serial_mul u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b),
    .p(m_p), .ctl(m_ctl));

  function automatic d_t clampv(d_t v, d_t lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  logic [CW+KW-1:0] idx;
  d_t cur_st, last_st, tin;
  logic [W-1:0] tabs;
  logic [4:0] ti;
  assign idx = {ch_r, k_r};
  assign cur_st = d_t'(st_r[idx]);
  assign last_st = d_t'(st_r[{ch_r, KW'(STAGES-1)}]);

  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r; k_nxt = k_r; ch_nxt = ch_r;
    x_nxt = x_r; prev_nxt = prev_r; t_nxt = t_r; xc_nxt = xc_r; sq_nxt = sq_r;
    tb_nxt = tb_r; ta_nxt = ta_r; tneg_nxt = tneg_r; be_nxt = be_r;
    ov_nxt = ov_r; os_nxt = os_r; obe_nxt = obe_r;
    m_start = 1'b0; m_a = '0; m_b = '0; st_we = 1'b0; st_wd = '0;
    tin = '0; tabs = '0; ti = '0;
    in_ready = (state_r == nllp_pkg::S_IDLE);
    if (ov_r && out_ready) ov_nxt = 1'b0;
    // tanh operand select
    case (state_r)
      nllp_pkg::S_TD: tin = x_r;
      nllp_pkg::S_TIN: tin = prev_r;
      default: tin = cur_st;
    endcase
    tin = clampv(tin, nllp_pkg::HALF_PI);
    tabs = (tin < 0) ? W'(-tin) : W'(tin);
    ti = (tabs[W-1:16] > 25) ? 5'd25 : tabs[20:16];
    case (state_r)
      nllp_pkg::S_IDLE: if (in_valid && in_ready) begin
        x_nxt = d_t'($signed(in_data.sample[SAMPLE_WIDTH-1:0]));
        ch_nxt = (CHANNELS > 1) ? CW'(in_data.channel) : '0;
        be_nxt = in_data.block_end; k_nxt = '0; ph_nxt = '0;
        state_nxt = nllp_pkg::S_DRIVE;
      end
      nllp_pkg::S_DRIVE: if (ph_r == 0) begin
        m_start = 1'b1; m_a = x_r; m_b = d_t'({1'b0, drive_r}); ph_nxt = 2'd1;
      end else if (ph_r == 1) ph_nxt = 2'd2;
      else if (!m_ctl.busy) begin
        x_nxt = d_t'(m_p >>> (SAMPLE_WIDTH - 9)); ph_nxt = '0;
        state_nxt = nllp_pkg::S_TD;
      end
      nllp_pkg::S_TD, nllp_pkg::S_TIN, nllp_pkg::S_TST: if (ph_r == 0) begin
        tb_nxt = d_t'(nllp_pkg::tanh_tab(ti));
        tneg_nxt = tin < 0;
        m_start = 1'b1;
        m_a = d_t'(nllp_pkg::tanh_tab(ti + 5'd1)) - d_t'(nllp_pkg::tanh_tab(ti));
        m_b = d_t'({1'b0, tabs[15:0]}); ph_nxt = 2'd1;
      end else if (ph_r == 1) ph_nxt = 2'd2;
      else if (!m_ctl.busy) begin
        ta_nxt = tb_r + d_t'(m_p >>> 16);
        if (tneg_r) ta_nxt = -(tb_r + d_t'(m_p >>> 16));
        ph_nxt = '0;
        case (state_r)
          nllp_pkg::S_TD: begin x_nxt = ta_nxt; state_nxt = nllp_pkg::S_FB; end
          nllp_pkg::S_TIN: begin t_nxt = ta_nxt; state_nxt = nllp_pkg::S_TST; end
          default: begin t_nxt = t_r - ta_nxt; state_nxt = nllp_pkg::S_UPD; end
        endcase
      end
      nllp_pkg::S_FB: if (ph_r == 0) begin
        m_start = 1'b1; m_a = last_st; m_b = d_t'({1'b0, res_r}); ph_nxt = 2'd1;
      end else if (ph_r == 1) ph_nxt = 2'd2;
      else if (!m_ctl.busy) begin
        prev_nxt = x_r - d_t'(m_p >>> 12); ph_nxt = '0;
        state_nxt = nllp_pkg::S_TIN;
      end
      nllp_pkg::S_UPD: if (ph_r == 0) begin
        m_start = 1'b1; m_a = t_r; m_b = d_t'({1'b0, cut_r}); ph_nxt = 2'd1;
      end else if (ph_r == 1) ph_nxt = 2'd2;
      else if (!m_ctl.busy) begin
        prev_nxt = clampv(cur_st + d_t'(m_p >>> 16), nllp_pkg::STAGE_LIM);
        st_we = 1'b1; st_wd = prev_nxt[23:0]; ph_nxt = '0;
        if (k_r == KW'(STAGES-1)) begin
          xc_nxt = clampv(prev_nxt, nllp_pkg::ONE_Q20);
          state_nxt = nllp_pkg::S_SQ;
        end else begin
          k_nxt = k_r + 1'b1; state_nxt = nllp_pkg::S_TIN;
        end
      end
      nllp_pkg::S_SQ, nllp_pkg::S_CUBE, nllp_pkg::S_CLIP: if (ph_r == 0) begin
        m_start = 1'b1;
        case (state_r)
          nllp_pkg::S_SQ: begin m_a = xc_r; m_b = xc_r; end
          nllp_pkg::S_CUBE: begin m_a = sq_r; m_b = xc_r; end
          default: begin m_a = sq_r; m_b = d_t'({1'b0, clip_r}); end
        endcase
        ph_nxt = 2'd1;
      end else if (ph_r == 1) ph_nxt = 2'd2;
      else if (!m_ctl.busy) begin
        ph_nxt = '0;
        case (state_r)
          nllp_pkg::S_SQ: begin sq_nxt = d_t'(m_p >>> 20); state_nxt = nllp_pkg::S_CUBE; end
          nllp_pkg::S_CUBE: begin sq_nxt = d_t'(m_p >>> 20); state_nxt = nllp_pkg::S_CLIP; end
          default: begin
            t_nxt = xc_r - d_t'(m_p >>> 16); state_nxt = nllp_pkg::S_OUT;
          end
        endcase
      end
      nllp_pkg::S_OUT: if (!ov_r) begin
        if (SAMPLE_WIDTH >= 21) t_nxt = t_r <<< (SAMPLE_WIDTH - 21);
        else t_nxt = t_r >>> (21 - SAMPLE_WIDTH);
        if (t_nxt > d_t'((1 <<< (SAMPLE_WIDTH-1)) - 1))
          os_nxt = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        else if (t_nxt < -d_t'(1 <<< (SAMPLE_WIDTH-1)))
          os_nxt = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else os_nxt = t_nxt[SAMPLE_WIDTH-1:0];
        obe_nxt = be_r; ov_nxt = 1'b1; state_nxt = nllp_pkg::S_IDLE;
      end
      default: state_nxt = nllp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nllp_pkg::S_IDLE; ph_r <= '0; ov_r <= 1'b0;
      drive_r <= 16'd7782; cut_r <= 17'd65536; res_r <= 15'd14336; clip_r <= '0;
      for (int i = 0; i < CHANNELS*STAGES; i++) st_r[i] <= '0;
    end else begin
      state_r <= state_nxt; ph_r <= ph_nxt; ov_r <= ov_nxt;
      if (st_we) st_r[idx] <= st_wd;
      if (cfg_we) begin
        case (cfg_index)
          nllp_pkg::REG_DRIVE: drive_r <= cfg_wdata[15:0];
          nllp_pkg::REG_CUTOFF: cut_r <= cfg_wdata;
          nllp_pkg::REG_RES: res_r <= cfg_wdata[14:0];
          nllp_pkg::REG_CLIP: clip_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    k_r <= k_nxt; ch_r <= ch_nxt; x_r <= x_nxt; prev_r <= prev_nxt; t_r <= t_nxt;
    xc_r <= xc_nxt; sq_r <= sq_nxt; tb_r <= tb_nxt; ta_r <= ta_nxt;
    tneg_r <= tneg_nxt; be_r <= be_nxt; os_r <= os_nxt; obe_r <= obe_nxt;
  end

  assign out_valid = ov_r;
  assign out_data.out_sample = os_r;
  assign out_data.block_end_out = obe_r;
endmodule

// ----- sv/nllp_checker.sv -----
// Port-level checks for the ladder low-pass core, bound to the top level.
// Depends on assert_macros.svh and nllp_pkg.
`include "assert_macros.svh"
module nllp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input nllp_pkg::out_item_t out_data
);
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `CHK_NEXT(a_out_drop, clk, rst_n, out_valid && out_ready, !out_valid)
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data))
endmodule

bind nonlinear_ladder_lowpass_core nllp_checker u_chk (.clk, .rst_n, .in_valid,
  .in_ready, .out_valid, .out_ready, .out_data);
